// ===== design/mups_pkg.sv =====
// Package for the masked unique pattern search unit.
// Sizes, codes, words passed between the cell row, the configuration block and the judge.
// No dependencies.
`default_nettype none

package mups_pkg;

    localparam int MAX_PATTERN = 128;
    localparam int OFFSET_BITS = 32;
    localparam int PTR_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
    localparam int NEFF_W      = PTR_W + 1;
    localparam int LEN_W       = 8;
    localparam int IDX_W       = 7;
    localparam int POS_W       = OFFSET_BITS + 1;
    localparam int GRP         = 16;
    localparam int NGRP        = (MAX_PATTERN + GRP - 1) / GRP;
    localparam int QDEPTH      = 8;
    localparam int QPTR_W      = 3;
    localparam int QCNT_W      = 4;
    localparam int ADDR_W      = 3;
    localparam int DATA_W      = 32;
    localparam int REG_IDX_W   = 1;

    localparam logic [REG_IDX_W-1:0] REG_PATTERN_LENGTH = 1'b0;

    localparam logic FUNC_LOAD = 1'b0;
    localparam logic FUNC_BYTE = 1'b1;

    typedef enum logic [1:0] {
        ST_UNIQUE = 2'd0,
        ST_NONE   = 2'd1,
        ST_AMBIG  = 2'd2,
        ST_LONG   = 2'd3
    } status_t;

    typedef logic [OFFSET_BITS-1:0] offset_t;

    typedef struct packed {
        logic [7:0] value;
        logic       care;
    } pat_t;

    // per-byte tag that travels alongside the comparison pipeline
    typedef struct packed {
        logic    valid;
        logic    last;
        logic    elig;
        logic    too_long;
        offset_t start;
    } meta_t;

    typedef struct packed {
        logic             shift;
        logic             clr;
        logic             rot;
        logic             load;
        logic [PTR_W-1:0] load_sel;
        logic [PTR_W-1:0] align;
        pat_t             load_pat;
    } cell_ctl_t;

    typedef struct packed {
        logic [NEFF_W-1:0] neff;
        logic [PTR_W-1:0]  align;
        logic              rotating;
    } cfg_state_t;

    typedef struct packed {
        status_t status;
        offset_t offset;
    } result_t;

    // clamp the programmed length to the pattern store depth
    function automatic logic [NEFF_W-1:0] eff_len(input logic [LEN_W-1:0] len);
        logic [NEFF_W-1:0] n;
        if (int'(len) > MAX_PATTERN)
            n = NEFF_W'(MAX_PATTERN);
        else
            n = NEFF_W'(len);
        return n;
    endfunction

endpackage

`default_nettype wire

// ===== design/mups_if.sv =====
// Valid/ready channels of the masked unique pattern search unit.
// Depends on mups_pkg for field widths.
`default_nettype none

interface mups_in_if;
    logic                       valid;
    logic                       ready;
    logic                       func;
    logic [mups_pkg::IDX_W-1:0] pattern_index;
    logic [7:0]                 pattern_value;
    logic                       pattern_care;
    logic [7:0]                 data_byte;
    logic                       last_byte;

    modport source (output valid, func, pattern_index, pattern_value, pattern_care,
                    data_byte, last_byte, input ready);
    modport sink   (input valid, func, pattern_index, pattern_value, pattern_care,
                    data_byte, last_byte, output ready);
endinterface

interface mups_out_if;
    logic                             valid;
    logic                             ready;
    logic [1:0]                       status;
    logic [mups_pkg::OFFSET_BITS-1:0] match_offset;

    modport source (output valid, status, match_offset, input ready);
    modport sink   (input valid, status, match_offset, output ready);
endinterface

`default_nettype wire

// ===== design/mups_cell.sv =====
// One cell of the search row: a window byte, one slot of the pattern ring and its compare flag.
// Depends on mups_pkg.
`default_nettype none

module mups_cell (
    input  wire                         clk,
    input  wire                         rst_n,
    input  wire  [mups_pkg::PTR_W-1:0]  cell_idx,
    input  mups_pkg::cell_ctl_t         ctl,
    input  wire  [7:0]                  win_in,
    output logic [7:0]                  win_out,
    input  mups_pkg::pat_t              pat_in,
    output mups_pkg::pat_t              pat_out,
    output logic                        ok
);
    import mups_pkg::*;

    logic [7:0] win_reg;
    logic [7:0] win_next;
    pat_t       pat_reg;
    logic       ok_reg;
    logic       ok_next;

    // after a last word the neighbours feed zeros; only a byte shifted in at that time survives
    always_comb
    begin
        win_next = win_reg;
        if (ctl.shift)
            win_next = (cell_idx == '0 || !ctl.clr) ? win_in : 8'h00;
        else if (ctl.clr)
            win_next = 8'h00;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            win_reg <= 8'h00;
        else
            win_reg <= win_next;
    end

    // ring slot holds pattern[(align - cell_idx) mod depth]
    always_ff @(posedge clk)
    begin
        if (ctl.rot)
            pat_reg <= pat_in;
        else if (ctl.load && ctl.load_sel == cell_idx)
            pat_reg <= ctl.load_pat;
    end

    assign ok_next = (cell_idx > ctl.align) || !pat_reg.care || (win_reg == pat_reg.value);

    always_ff @(posedge clk)
    begin
        ok_reg <= ok_next;
    end

    assign win_out = win_reg;
    assign pat_out = pat_reg;
    assign ok      = ok_reg;

endmodule

`default_nettype wire

// ===== design/mups_cfg.sv =====
// APB register for the pattern length and the aligner that rotates the pattern ring to match it.
// Depends on mups_pkg.
`default_nettype none

module mups_cfg (
    input  wire                          clk,
    input  wire                          rst_n,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [mups_pkg::ADDR_W-1:0]  paddr,
    input  wire  [mups_pkg::DATA_W-1:0]  pwdata,
    output logic [mups_pkg::DATA_W-1:0]  prdata,
    output logic                         pready,
    output mups_pkg::cfg_state_t         cfg_st
);
    import mups_pkg::*;

    logic [LEN_W-1:0]     len_reg;
    logic [LEN_W-1:0]     len_next;
    logic [PTR_W-1:0]     align_reg;
    logic [PTR_W-1:0]     align_next;
    logic [PTR_W-1:0]     target_reg;
    logic [PTR_W-1:0]     target_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr;
    logic [NEFF_W-1:0]    wr_neff;
    logic                 rotating;

    assign reg_idx  = paddr[ADDR_W-1:2];
    assign pready   = 1'b1;
    assign wr       = psel && penable && pwrite && pready;
    assign wr_neff  = eff_len(pwdata[LEN_W-1:0]);
    assign rotating = (align_reg != target_reg);

    always_comb
    begin
        len_next    = len_reg;
        target_next = target_reg;
        if (wr && reg_idx == REG_PATTERN_LENGTH)
        begin
            len_next = pwdata[LEN_W-1:0];
            // a zero length matches nothing, so the ring stays where it is
            if (wr_neff != '0)
                target_next = PTR_W'(wr_neff - NEFF_W'(1));
        end
    end

    always_comb
    begin
        align_next = align_reg;
        if (rotating)
        begin
            if (int'(align_reg) == MAX_PATTERN - 1)
                align_next = '0;
            else
                align_next = align_reg + PTR_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg    <= LEN_W'(1);
            align_reg  <= '0;
            target_reg <= '0;
        end
        else
        begin
            len_reg    <= len_next;
            align_reg  <= align_next;
            target_reg <= target_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        case (reg_idx)
            REG_PATTERN_LENGTH: prdata = DATA_W'(len_reg);
            default:            prdata = '0;
        endcase
    end

    assign cfg_st.neff     = eff_len(len_reg);
    assign cfg_st.align    = align_reg;
    assign cfg_st.rotating = rotating;

    a_rot_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (align_reg != target_reg) |=> (align_reg != $past(align_reg)))
        else $error("aligner stalled while rotating");

    a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (align_reg == target_reg) |=> $stable(align_reg))
        else $error("ring alignment moved while settled");

endmodule

`default_nettype wire

// ===== design/mups_judge.sv =====
// Registered AND tree over the cell flags, match tally and result queue.
// Depends on mups_pkg and mups_if.
`default_nettype none

module mups_judge (
    input  wire                              clk,
    input  wire                              rst_n,
    input  wire  [mups_pkg::MAX_PATTERN-1:0] ok_vec,
    input  mups_pkg::meta_t                  m1,
    input  wire                              acc_last,
    output logic                             room,
    mups_out_if.source                       dout
);
    import mups_pkg::*;

    localparam logic [1:0] TALLY_SAT = 2'd2;

    meta_t                 m2_reg, m3_reg, m4_reg;
    logic [NGRP*GRP-1:0]   ok_pad;
    logic [NGRP-1:0]       grp_next;
    logic [NGRP-1:0]       grp_reg;
    logic                  hit_reg;
    logic [1:0]            tally_reg, tally_next, tally_upd;
    offset_t               first_reg, first_next, first_upd;
    logic                  fin_hit;
    logic                  q_wr;
    logic                  q_rd;
    result_t               q_word;
    result_t               q_mem [QDEPTH];
    logic [QPTR_W-1:0]     wp_reg, rp_reg;
    logic [QCNT_W-1:0]     cnt_reg, cnt_next;
    logic [QCNT_W-1:0]     pend_reg, pend_next;

    always_comb
    begin
        ok_pad = '1;
        ok_pad[MAX_PATTERN-1:0] = ok_vec;
        for (int g = 0; g < NGRP; g++)
            grp_next[g] = &ok_pad[g*GRP +: GRP];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m2_reg <= '0;
            m3_reg <= '0;
            m4_reg <= '0;
        end
        else
        begin
            m2_reg <= m1;
            m3_reg <= m2_reg;
            m4_reg <= m3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        grp_reg <= grp_next;
        hit_reg <= &grp_reg;
    end

    assign fin_hit   = m4_reg.valid && m4_reg.elig && hit_reg;
    assign tally_upd = (fin_hit && tally_reg != TALLY_SAT) ? tally_reg + 2'd1 : tally_reg;
    assign first_upd = (fin_hit && tally_reg == 2'd0) ? m4_reg.start : first_reg;
    assign q_wr      = m4_reg.valid && m4_reg.last;

    always_comb
    begin
        q_word.status = ST_UNIQUE;
        q_word.offset = '0;
        if (m4_reg.too_long)
            q_word.status = ST_LONG;
        else if (tally_upd == 2'd0)
            q_word.status = ST_NONE;
        else if (tally_upd == TALLY_SAT)
            q_word.status = ST_AMBIG;
        else
            q_word.offset = first_upd;

        tally_next = tally_upd;
        first_next = first_upd;
        if (q_wr)
        begin
            tally_next = '0;
            first_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally_reg <= '0;
            first_reg <= '0;
        end
        else
        begin
            tally_reg <= tally_next;
            first_reg <= first_next;
        end
    end

    // result queue; pend counts last words from acceptance until delivered
    assign q_rd = dout.valid && dout.ready;

    always_comb
    begin
        cnt_next  = cnt_reg;
        pend_next = pend_reg;
        if (q_wr && !q_rd)
            cnt_next = cnt_reg + QCNT_W'(1);
        else if (!q_wr && q_rd)
            cnt_next = cnt_reg - QCNT_W'(1);
        if (acc_last && !q_rd)
            pend_next = pend_reg + QCNT_W'(1);
        else if (!acc_last && q_rd)
            pend_next = pend_reg - QCNT_W'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg   <= '0;
            rp_reg   <= '0;
            cnt_reg  <= '0;
            pend_reg <= '0;
        end
        else
        begin
            if (q_wr)
                wp_reg <= wp_reg + QPTR_W'(1);
            if (q_rd)
                rp_reg <= rp_reg + QPTR_W'(1);
            cnt_reg  <= cnt_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_wr)
            q_mem[wp_reg] <= q_word;
    end

    assign room              = (pend_reg < QCNT_W'(QDEPTH));
    assign dout.valid        = (cnt_reg != '0);
    assign dout.status       = q_mem[rp_reg].status;
    assign dout.match_offset = q_mem[rp_reg].offset;

    a_queue_counted: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= pend_reg)
        else $error("result queue holds a word that was never booked");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= QCNT_W'(QDEPTH))
        else $error("more results in flight than the queue can hold");

    a_last_queued: assert property (@(posedge clk) disable iff (!rst_n)
        (m4_reg.valid && m4_reg.last) |=> (cnt_reg != '0))
        else $error("finished search left no result word");

endmodule

`default_nettype wire

// ===== design/masked_unique_pattern_search_unit.sv =====
// Top level of the masked unique pattern search unit: window/pattern cell row, judge, APB block.
// Depends on mups_pkg, mups_if, mups_cell, mups_judge and mups_cfg.
//
// Usage. Words on din with func = load write one pattern entry (value and care bit) at
// pattern_index; words with func = byte stream the haystack, and last_byte marks its end.
// The APB register pattern_length (address 0) sets how many pattern bytes each window uses.
// Every haystack byte slides a window through a row of cells; each cell checks one window
// byte against its pattern slot, and a registered AND tree folds the flags. On the last byte
// one word leaves on dout: unique match with start offset, no match, ambiguous, or too long.
// Throughput: one input word per cycle while din.ready is high, loads and bytes alike.
// A result passes the cell flag, group AND and final AND registers before it enters the queue.
// Writing pattern_length rotates the pattern ring one slot per cycle into its new alignment;
// din.ready stays low while it turns.
// A queue of QDEPTH result words parts the two sides; din.ready also drops when that many
// results are pending, so a stalled receiver loses nothing.
// Reset clears the window, counters and tally and sets pattern_length to 1; pattern entries
// are undefined until written and keep their values from one search to the next.
`default_nettype none

module masked_unique_pattern_search_unit (
    input  wire                          clk,
    input  wire                          rst_n,
    mups_in_if.sink                      din,
    mups_out_if.source                   dout,
    input  wire                          psel,
    input  wire                          penable,
    input  wire                          pwrite,
    input  wire  [mups_pkg::ADDR_W-1:0]  paddr,
    input  wire  [mups_pkg::DATA_W-1:0]  pwdata,
    output logic [mups_pkg::DATA_W-1:0]  prdata,
    output logic                         pready
);
    import mups_pkg::*;

    localparam logic [POS_W-1:0] LIMIT = POS_W'(1) << OFFSET_BITS;
    localparam int SW = ((IDX_W > PTR_W) ? IDX_W : PTR_W) + 1;

    cfg_state_t        cfg_st;
    cell_ctl_t         ctl;
    logic              room;
    logic              in_acc;
    logic              acc_byte;
    logic              acc_last;
    logic [POS_W-1:0]  pos_reg, pos_next, pos_inc;
    logic              clr_pend_reg;
    meta_t             m1_reg, m1_next;
    logic [SW-1:0]     sel_diff;
    logic [7:0]        win_in  [MAX_PATTERN];
    logic [7:0]        win_out [MAX_PATTERN];
    pat_t              pat_in  [MAX_PATTERN];
    pat_t              pat_out [MAX_PATTERN];
    logic [MAX_PATTERN-1:0] ok_vec;

    mups_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg_st  (cfg_st)
    );

    assign din.ready = room && !cfg_st.rotating;
    assign in_acc    = din.valid && din.ready;
    assign acc_byte  = in_acc && (din.func == FUNC_BYTE);
    assign acc_last  = acc_byte && din.last_byte;

    // byte counter saturates one past the limit
    assign pos_inc = (pos_reg <= LIMIT) ? pos_reg + POS_W'(1) : pos_reg;

    always_comb
    begin
        pos_next = pos_reg;
        if (acc_byte)
            pos_next = din.last_byte ? '0 : pos_inc;
    end

    always_comb
    begin
        m1_next.valid    = acc_byte;
        m1_next.last     = din.last_byte;
        m1_next.elig     = (cfg_st.neff != '0) && (pos_inc <= LIMIT)
                           && (pos_inc >= POS_W'(cfg_st.neff));
        m1_next.too_long = (pos_inc > LIMIT);
        m1_next.start    = OFFSET_BITS'(pos_inc - POS_W'(cfg_st.neff));
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            clr_pend_reg <= 1'b0;
            m1_reg       <= '0;
        end
        else
        begin
            pos_reg      <= pos_next;
            clr_pend_reg <= acc_last;
            m1_reg       <= m1_next;
        end
    end

    // ring slot that holds pattern entry idx: (align - idx) mod depth
    always_comb
    begin
        if (SW'(cfg_st.align) >= SW'(din.pattern_index))
            sel_diff = SW'(cfg_st.align) - SW'(din.pattern_index);
        else
            sel_diff = SW'(cfg_st.align) + SW'(MAX_PATTERN) - SW'(din.pattern_index);
    end

    always_comb
    begin
        ctl.shift          = acc_byte;
        ctl.clr            = clr_pend_reg;
        ctl.rot            = cfg_st.rotating;
        ctl.load           = in_acc && (din.func == FUNC_LOAD)
                             && (int'(din.pattern_index) < MAX_PATTERN);
        ctl.load_sel       = PTR_W'(sel_diff);
        ctl.align          = cfg_st.align;
        ctl.load_pat.value = din.pattern_value;
        ctl.load_pat.care  = din.pattern_care;
    end

    for (genvar w = 0; w < MAX_PATTERN; w++)
    begin : g_cell
        localparam int PREV = (w == 0) ? MAX_PATTERN - 1 : w - 1;

        if (w == 0)
        begin : g_head
            assign win_in[w] = din.data_byte;
        end
        else
        begin : g_body
            assign win_in[w] = win_out[w-1];
        end
        assign pat_in[w] = pat_out[PREV];

        mups_cell u_cell (
            .clk      (clk),
            .rst_n    (rst_n),
            .cell_idx (PTR_W'(w)),
            .ctl      (ctl),
            .win_in   (win_in[w]),
            .win_out  (win_out[w]),
            .pat_in   (pat_in[w]),
            .pat_out  (pat_out[w]),
            .ok       (ok_vec[w])
        );
    end

    mups_judge u_judge (
        .clk      (clk),
        .rst_n    (rst_n),
        .ok_vec   (ok_vec),
        .m1       (m1_reg),
        .acc_last (acc_last),
        .room     (room),
        .dout     (dout)
    );

    a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
        clr_pend_reg |-> (pos_reg == '0))
        else $error("byte count survived the end of a search");

endmodule

`default_nettype wire
